@@ rtl/core/gens_pkg.sv @@
// Shared constants, codes, command struct and pair slot function for the
// excitable node simulator. No dependencies.
package gens_pkg;

	localparam int MAX_NODES   = 256;
	localparam int MAX_EDGES   = 4096;
	localparam int COUNT_WIDTH = 17;
	localparam int NODE_W      = 8;
	localparam int EDGE_W      = 12;
	localparam int LEN_W       = 8;
	localparam int RND_W       = 16;
	localparam int THR_W       = 17;
	localparam int BURN_W      = 16;
	localparam int NCNT_W      = 9;
	localparam int STEP_W      = 17;
	localparam int CFG_W       = 17;
	localparam int CFG_IDX_W   = 2;
	localparam int PAIR_SLOTS  = MAX_NODES * (MAX_NODES - 1) / 2;
	localparam int SLOT_W      = $clog2(PAIR_SLOTS);

	localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};
	localparam logic [STEP_W-1:0]      STEP_MAX  = {STEP_W{1'b1}};

	localparam logic [2:0] REQ_EDGE = 3'd0;
	localparam logic [2:0] REQ_LIST = 3'd1;
	localparam logic [2:0] REQ_SET  = 3'd2;
	localparam logic [2:0] REQ_UPD  = 3'd3;
	localparam logic [2:0] REQ_END  = 3'd4;
	localparam logic [2:0] REQ_PAIR = 3'd5;

	localparam logic [1:0] ST_EXC = 2'b01;
	localparam logic [1:0] ST_REF = 2'b00;
	localparam logic [1:0] ST_SUS = 2'b11;

	localparam logic [CFG_IDX_W-1:0] CFG_FIRE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RECOV = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BURN  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_NODES = 2'd3;

	typedef struct packed {
		logic              rd;
		logic              inc;
		logic [SLOT_W-1:0] slot;
	} pair_cmd_t;

	function automatic logic [SLOT_W-1:0] pair_slot(input logic [NODE_W-1:0] r,
			input logic [NODE_W-1:0] c);
		logic [15:0] tri_v;
		logic [16:0] s;
		tri_v = {8'd0, r} * ({8'd0, r} + 16'd1);
		s = {1'b0, r, 8'd0} - {2'b00, tri_v[15:1]} + {9'd0, c} - {9'd0, r} - 17'd1;
		return s[SLOT_W-1:0];
	endfunction

endpackage

@@ rtl/core/gens_pair_store.sv @@
// Pair coactivation count store: clearing pass after reset, reads and
// saturating read-modify-write increments. Depends on gens_pkg.
module gens_pair_store (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  gens_pkg::pair_cmd_t                   cmd,
	output logic [gens_pkg::COUNT_WIDTH-1:0]      rdata,
	output logic                                  ready
);
	import gens_pkg::*;

	logic [COUNT_WIDTH-1:0] mem [PAIR_SLOTS];
	logic [SLOT_W-1:0]      clr_q;
	logic                   ready_q;
	logic                   inc_s1;
	logic [SLOT_W-1:0]      slot_s1;

	assign ready = ready_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q   <= '0;
			ready_q <= 1'b0;
			inc_s1  <= 1'b0;
		end else begin
			if (!ready_q) begin
				clr_q <= clr_q + 1'b1;
				if (clr_q == SLOT_W'(PAIR_SLOTS - 1)) ready_q <= 1'b1;
			end
			inc_s1 <= cmd.inc;
		end
	end

	always_ff @(posedge clk) begin
		slot_s1 <= cmd.slot;
	end

	// write back the incremented word in the cycle after its read
	always_ff @(posedge clk) begin
		if (!ready_q) begin
			mem[clr_q] <= '0;
		end else if (inc_s1) begin
			mem[slot_s1] <= (rdata == COUNT_MAX) ? rdata : rdata + 1'b1;
		end
		if (cmd.rd || cmd.inc) rdata <= mem[cmd.slot];
	end

endmodule

@@ rtl/core/graph_excitable_node_simulator.sv @@
// Top level of the excitable node simulator: request sequencer, graph and
// state memories, output register. Depends on gens_pkg and gens_pair_store.
//
// After reset the pair count store is swept to zero, all 32640 slots, with
// in_ready low; configuration writes are taken throughout. One request is
// worked at a time, each returning one word. An update of a susceptible node
// walks its neighbor list, reading for each entry the neighbor store and then
// the state memory. An end of step commits all node states through the single
// port of the state memories; past burn-in it first checks each node, each
// later node of each excited node, and counts each excited pair.
module graph_excitable_node_simulator (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [gens_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [gens_pkg::CFG_W-1:0]          cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [2:0]                          req_type,
	input  logic [gens_pkg::NODE_W-1:0]         node_index,
	input  logic [gens_pkg::NODE_W-1:0]         other_index,
	input  logic [gens_pkg::EDGE_W-1:0]         edge_address,
	input  logic [gens_pkg::EDGE_W-1:0]         list_start,
	input  logic [gens_pkg::LEN_W-1:0]          list_length,
	input  logic signed [1:0]                   initial_state,
	input  logic [gens_pkg::RND_W-1:0]          random_value,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [1:0]                   new_state,
	output logic [gens_pkg::COUNT_WIDTH-1:0]    pair_count,
	output logic [gens_pkg::STEP_W-1:0]         step_number,
	output logic                                status
);
	import gens_pkg::*;

	localparam logic [4:0] S_IDLE    = 5'd0;
	localparam logic [4:0] S_EXEC    = 5'd1;
	localparam logic [4:0] S_UPD_CHK = 5'd2;
	localparam logic [4:0] S_NB_RD   = 5'd3;
	localparam logic [4:0] S_NB_ST   = 5'd4;
	localparam logic [4:0] S_NB_CHK  = 5'd5;
	localparam logic [4:0] S_UPD_WR  = 5'd6;
	localparam logic [4:0] S_END_I   = 5'd7;
	localparam logic [4:0] S_END_CI  = 5'd8;
	localparam logic [4:0] S_END_K   = 5'd9;
	localparam logic [4:0] S_END_CK  = 5'd10;
	localparam logic [4:0] S_END_WR  = 5'd11;
	localparam logic [4:0] S_COM_RD  = 5'd12;
	localparam logic [4:0] S_COM_WR  = 5'd13;
	localparam logic [4:0] S_PR_DATA = 5'd14;
	localparam logic [4:0] S_FIN     = 5'd15;

	localparam int LIST_W = EDGE_W + LEN_W;

	// configuration
	logic [THR_W-1:0]  fire_q, recov_q;
	logic [BURN_W-1:0] burn_q;
	logic [NCNT_W-1:0] ncount_q, n;

	// captured request
	logic [2:0]        req_q;
	logic [NODE_W-1:0] node_q, other_q;
	logic [EDGE_W-1:0] eaddr_q, lstart_q;
	logic [LEN_W-1:0]  llen_q;
	logic [1:0]        sbits_q;
	logic [RND_W-1:0]  rnd_q;

	logic [4:0]        state_q;
	logic [STEP_W-1:0] step_q;

	// walk registers
	logic [EDGE_W-1:0] pos_q;
	logic [LEN_W-1:0]  kcnt_q;
	logic [NCNT_W-1:0] i_q, k_q, j_q;
	logic [SLOT_W-1:0] base_q, slot_q;

	// result
	logic [1:0]             res_state_q;
	logic [COUNT_WIDTH-1:0] res_count_q;
	logic                   res_status_q;
	logic                   out_valid_q;
	logic [1:0]             out_state_q;
	logic [COUNT_WIDTH-1:0] out_count_q;
	logic [STEP_W-1:0]      out_step_q;
	logic                   out_status_q;

	// memories
	logic [NODE_W-1:0] nbr_mem  [MAX_EDGES];
	logic [LIST_W-1:0] list_mem [MAX_NODES];
	logic [1:0]        prev_mem [MAX_NODES];
	logic [1:0]        next_mem [MAX_NODES];
	logic [MAX_NODES-1:0] lvalid_q;

	logic [NODE_W-1:0] nbr_rd;
	logic [LIST_W-1:0] list_rd;
	logic [1:0]        prev_rd, next_rd;

	logic              nbr_we, list_we, prev_we, next_we;
	logic [NODE_W-1:0] prev_ra, next_ra, prev_wa, next_wa;
	logic [1:0]        prev_wd, next_wd, set_code;

	pair_cmd_t              pcmd;
	logic [COUNT_WIDTH-1:0] pair_rd;
	logic                   pair_ready;

	logic node_ok, other_ok, pair_ok;
	logic [LEN_W-1:0]  cur_len;
	logic [SLOT_W-1:0] base_next;

	assign n        = (ncount_q > NCNT_W'(MAX_NODES)) ? NCNT_W'(MAX_NODES) : ncount_q;
	assign node_ok  = {1'b0, node_q} < n;
	assign other_ok = {1'b0, other_q} < n;
	assign pair_ok  = (node_q < other_q) && other_ok;
	assign set_code = (sbits_q == ST_EXC) ? ST_EXC : (sbits_q == ST_REF) ? ST_REF : ST_SUS;
	assign cur_len  = lvalid_q[node_q] ? list_rd[LEN_W-1:0] : '0;
	assign base_next = base_q + SLOT_W'(MAX_NODES - 1) - SLOT_W'(i_q);

	assign in_ready    = (state_q == S_IDLE) && pair_ready;
	assign out_valid   = out_valid_q;
	assign new_state   = out_state_q;
	assign pair_count  = out_count_q;
	assign step_number = out_step_q;
	assign status      = out_status_q;

	gens_pair_store u_pair (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (pcmd),
		.rdata  (pair_rd),
		.ready  (pair_ready)
	);

	always_comb begin
		nbr_we  = (state_q == S_EXEC) && (req_q == REQ_EDGE) && other_ok;
		list_we = (state_q == S_EXEC) && (req_q == REQ_LIST) && node_ok;
		prev_ra = (state_q == S_NB_ST) ? nbr_rd : node_q;
		unique case (state_q)
			S_END_I: next_ra = i_q[NODE_W-1:0];
			S_END_K: next_ra = k_q[NODE_W-1:0];
			default: next_ra = j_q[NODE_W-1:0];
		endcase
		prev_we = 1'b0;
		prev_wa = node_q;
		prev_wd = set_code;
		next_we = 1'b0;
		next_wa = node_q;
		next_wd = set_code;
		if ((state_q == S_EXEC) && (req_q == REQ_SET) && node_ok) begin
			prev_we = 1'b1;
			next_we = 1'b1;
		end
		if (state_q == S_UPD_WR) begin
			next_we = 1'b1;
			next_wd = res_state_q;
		end
		if (state_q == S_COM_WR) begin
			prev_we = 1'b1;
			prev_wa = j_q[NODE_W-1:0];
			prev_wd = next_rd;
		end
		pcmd.rd   = (state_q == S_EXEC) && (req_q == REQ_PAIR) && pair_ok;
		pcmd.inc  = (state_q == S_END_CK) && (next_rd == ST_EXC);
		pcmd.slot = (state_q == S_EXEC) ? pair_slot(node_q, other_q) : slot_q;
	end

	always_ff @(posedge clk) begin
		if (nbr_we) nbr_mem[eaddr_q] <= other_q;
		nbr_rd <= nbr_mem[pos_q];
	end

	always_ff @(posedge clk) begin
		if (list_we) list_mem[node_q] <= {lstart_q, llen_q};
		list_rd <= list_mem[node_q];
	end

	always_ff @(posedge clk) begin
		if (prev_we) prev_mem[prev_wa] <= prev_wd;
		prev_rd <= prev_mem[prev_ra];
	end

	always_ff @(posedge clk) begin
		if (next_we) next_mem[next_wa] <= next_wd;
		next_rd <= next_mem[next_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fire_q   <= THR_W'(66);
			recov_q  <= THR_W'(66);
			burn_q   <= BURN_W'(1000);
			ncount_q <= NCNT_W'(256);
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_FIRE:  fire_q   <= cfg_data[THR_W-1:0];
				CFG_RECOV: recov_q  <= cfg_data[THR_W-1:0];
				CFG_BURN:  burn_q   <= cfg_data[BURN_W-1:0];
				CFG_NODES: ncount_q <= cfg_data[NCNT_W-1:0];
				default:   ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			req_q    <= req_type;
			node_q   <= node_index;
			other_q  <= other_index;
			eaddr_q  <= edge_address;
			lstart_q <= list_start;
			llen_q   <= list_length;
			sbits_q  <= initial_state;
			rnd_q    <= random_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			step_q       <= STEP_W'(1);
			lvalid_q     <= '0;
			out_valid_q  <= 1'b0;
			pos_q        <= '0;
			kcnt_q       <= '0;
			i_q          <= '0;
			k_q          <= '0;
			j_q          <= '0;
			base_q       <= '0;
			slot_q       <= '0;
			res_state_q  <= ST_REF;
			res_count_q  <= '0;
			res_status_q <= 1'b0;
			out_state_q  <= ST_REF;
			out_count_q  <= '0;
			out_step_q   <= '0;
			out_status_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && (state_q != S_FIN)) out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_valid && in_ready) state_q <= S_EXEC;
				end
				S_EXEC: begin
					res_count_q <= '0;
					unique case (req_q)
						REQ_EDGE: begin
							res_state_q  <= ST_REF;
							res_status_q <= !other_ok;
							state_q      <= S_FIN;
						end
						REQ_LIST: begin
							res_state_q  <= ST_REF;
							res_status_q <= !node_ok;
							if (node_ok) lvalid_q[node_q] <= 1'b1;
							state_q      <= S_FIN;
						end
						REQ_SET: begin
							res_state_q  <= node_ok ? set_code : ST_REF;
							res_status_q <= !node_ok;
							state_q      <= S_FIN;
						end
						REQ_UPD: begin
							res_state_q  <= ST_REF;
							res_status_q <= !node_ok;
							state_q      <= node_ok ? S_UPD_CHK : S_FIN;
						end
						REQ_END: begin
							res_state_q  <= ST_REF;
							res_status_q <= 1'b0;
							i_q    <= '0;
							j_q    <= '0;
							base_q <= '0;
							state_q <= ({1'b0, step_q} > {2'b00, burn_q}) ? S_END_I : S_COM_RD;
						end
						REQ_PAIR: begin
							res_state_q  <= ST_REF;
							res_status_q <= !pair_ok;
							state_q      <= pair_ok ? S_PR_DATA : S_FIN;
						end
						default: begin
							res_state_q  <= ST_REF;
							res_status_q <= 1'b1;
							state_q      <= S_FIN;
						end
					endcase
				end
				S_UPD_CHK: begin
					if (prev_rd == ST_EXC) begin
						res_state_q <= ST_REF;
						state_q     <= S_UPD_WR;
					end else if (prev_rd == ST_REF) begin
						res_state_q <= ({1'b0, rnd_q} < recov_q) ? ST_SUS : ST_REF;
						state_q     <= S_UPD_WR;
					end else begin
						pos_q   <= list_rd[LIST_W-1:LEN_W];
						kcnt_q  <= cur_len;
						state_q <= S_NB_RD;
					end
				end
				S_NB_RD: begin
					if (kcnt_q == '0) begin
						res_state_q <= ({1'b0, rnd_q} < fire_q) ? ST_EXC : ST_SUS;
						state_q     <= S_UPD_WR;
					end else begin
						state_q <= S_NB_ST;
					end
				end
				S_NB_ST: begin
					if ({1'b0, nbr_rd} >= n) begin
						pos_q   <= pos_q + 1'b1;
						kcnt_q  <= kcnt_q - 1'b1;
						state_q <= S_NB_RD;
					end else begin
						state_q <= S_NB_CHK;
					end
				end
				S_NB_CHK: begin
					if (prev_rd == ST_EXC) begin
						res_state_q <= ST_EXC;
						state_q     <= S_UPD_WR;
					end else begin
						pos_q   <= pos_q + 1'b1;
						kcnt_q  <= kcnt_q - 1'b1;
						state_q <= S_NB_RD;
					end
				end
				S_UPD_WR: state_q <= S_FIN;
				S_END_I: begin
					state_q <= (i_q >= n) ? S_COM_RD : S_END_CI;
				end
				S_END_CI: begin
					if (next_rd == ST_EXC) begin
						k_q     <= i_q + 1'b1;
						slot_q  <= base_q;
						state_q <= S_END_K;
					end else begin
						base_q  <= base_next;
						i_q     <= i_q + 1'b1;
						state_q <= S_END_I;
					end
				end
				S_END_K: begin
					if (k_q >= n) begin
						base_q  <= base_next;
						i_q     <= i_q + 1'b1;
						state_q <= S_END_I;
					end else begin
						state_q <= S_END_CK;
					end
				end
				S_END_CK: begin
					if (next_rd == ST_EXC) begin
						state_q <= S_END_WR;
					end else begin
						k_q     <= k_q + 1'b1;
						slot_q  <= slot_q + 1'b1;
						state_q <= S_END_K;
					end
				end
				S_END_WR: begin
					k_q     <= k_q + 1'b1;
					slot_q  <= slot_q + 1'b1;
					state_q <= S_END_K;
				end
				S_COM_RD: state_q <= S_COM_WR;
				S_COM_WR: begin
					if (j_q == NCNT_W'(MAX_NODES - 1)) begin
						if (step_q != STEP_MAX) step_q <= step_q + 1'b1;
						state_q <= S_FIN;
					end else begin
						j_q     <= j_q + 1'b1;
						state_q <= S_COM_RD;
					end
				end
				S_PR_DATA: begin
					res_count_q <= pair_rd;
					state_q     <= S_FIN;
				end
				S_FIN: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q  <= 1'b1;
						out_state_q  <= res_state_q;
						out_count_q  <= res_count_q;
						out_step_q   <= step_q;
						out_status_q <= res_status_q;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

@@ rtl/core/gens_checker.sv @@
// Port level checks for the excitable node simulator, bound to the top
// level. Depends on the top level's port list only.
module gens_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [1:0]  new_state,
	input logic [16:0] pair_count,
	input logic [16:0] step_number,
	input logic        status
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(pair_count)
			&& $stable(step_number) && $stable(new_state) && $stable(status))
		else $error("result word changed while stalled");

	a_reject: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status |-> new_state == 2'b00 && pair_count == 17'd0)
		else $error("rejected word carries data");

	a_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> step_number != 17'd0)
		else $error("step number zero");

	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && pair_count != 17'd0 |-> new_state == 2'b00 && !status)
		else $error("pair count with state or status");

	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> new_state != 2'b10)
		else $error("illegal state code");

endmodule

bind graph_excitable_node_simulator gens_checker u_gens_checker (.*);
